### src/tlbclk_pkg.sv
// Shared constants and types for the clock-replacement TLB.
// Used by tlbclk_cell and tlb_lookup_clock_replace_top; depends on nothing.
`default_nettype none

package tlbclk_pkg;

   localparam int ENTRIES  = 16;
   localparam int VPN_BITS = 20;
   localparam int PFN_BITS = 20;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Values that ripple from one cell to the next along the row.
   typedef struct packed {
      logic                hit_seen;
      logic                all_valid;
      logic                all_used;
      logic [PFN_BITS-1:0] frame;
   } chain_type;

   // Values broadcast to every cell for the request under lookup.
   typedef struct packed {
      logic                commit;
      logic                miss;
      logic                all_valid;
      logic                write;
      logic [VPN_BITS-1:0] page;
      logic [PFN_BITS-1:0] fill;
   } bcast_type;

endpackage

`default_nettype wire

### src/tlbclk_cell.sv
// One TLB entry with its valid, used and dirty bits and its share of the
// hit, fill and clock-sweep chains. Depends on tlbclk_pkg.
`default_nettype none

module tlbclk_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tlbclk_pkg::bcast_type        bcast,
   input  wire logic                         take_wrap,
   input  wire tlbclk_pkg::chain_type        chain_left,
   output tlbclk_pkg::chain_type             chain_right,
   output logic                              touch
);

   logic                            valid_ff, valid_in;
   logic                            used_ff, used_in;
   logic                            dirty_ff, dirty_in;
   logic [tlbclk_pkg::VPN_BITS-1:0] page_ff;
   logic [tlbclk_pkg::PFN_BITS-1:0] frame_ff;
   logic                            match;
   logic                            hit_here;
   logic                            fill_here;
   logic                            sweep_clear;

   always_comb begin
      match       = valid_ff && (page_ff == bcast.page);
      hit_here    = match && !chain_left.hit_seen;
      chain_right.hit_seen  = chain_left.hit_seen | match;
      chain_right.all_valid = chain_left.all_valid & valid_ff;
      chain_right.all_used  = chain_left.all_used & used_ff;
      chain_right.frame     = chain_left.frame | (hit_here ? frame_ff : '0);

      if (bcast.all_valid) begin
         fill_here = bcast.miss && ((chain_left.all_used && !used_ff) || take_wrap);
      end else begin
         fill_here = bcast.miss && chain_left.all_valid && !valid_ff;
      end
      sweep_clear = bcast.miss && bcast.all_valid && chain_left.all_used && used_ff;
      touch       = hit_here | fill_here;

      valid_in = valid_ff | fill_here;
      if (touch) begin
         used_in = 1'b1;
      end else if (sweep_clear) begin
         used_in = 1'b0;
      end else begin
         used_in = used_ff;
      end
      if (fill_here) begin
         dirty_in = bcast.write;
      end else if (hit_here) begin
         dirty_in = dirty_ff | bcast.write;
      end else begin
         dirty_in = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         used_ff  <= 1'b0;
         dirty_ff <= 1'b0;
      end else if (bcast.commit) begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         dirty_ff <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.commit && fill_here) begin
         page_ff  <= bcast.page;
         frame_ff <= bcast.fill;
      end
   end

endmodule

`default_nettype wire

### src/tlb_lookup_clock_replace_top.sv
// Top level of the fully associative TLB with clock replacement.
// Depends on tlbclk_pkg and tlbclk_cell.
//
// Usage:
// A request on the req_ channel carries a virtual page number, a write flag
// and the page-table frame to install on a miss. It is taken at a clock edge
// where req_valid is high and req_stall is low. Each request yields exactly
// one result on the rsp_ channel: the frame number and a hit flag.
// The request is registered at acceptance, and in the lookup state the row of
// entry cells resolves hit, free entry or clock victim and updates its bits.
// The result is then held in the output register. One request is in the
// block at a time: a new one is taken only after the last one has been
// committed. The ripple chain through the row of cells sets the length of
// the lookup cycle.
// While rsp_stall holds a pending result, the lookup waits and req_stall
// stays high. Synchronous reset clears all valid, used and dirty bits and
// empties the block; stored pages and frames are kept but unused.
`default_nettype none

module tlb_lookup_clock_replace_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [tlbclk_pkg::VPN_BITS-1:0] req_vpn,
   input  wire logic                            req_write_access,
   input  wire logic [tlbclk_pkg::PFN_BITS-1:0] req_fill_pfn,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [tlbclk_pkg::PFN_BITS-1:0]      rsp_pfn,
   output logic                                 rsp_hit
);

   tlbclk_pkg::state_type           state_ff, state_in;
   logic [tlbclk_pkg::VPN_BITS-1:0] vpn_ff;
   logic                            write_ff;
   logic [tlbclk_pkg::PFN_BITS-1:0] fill_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tlbclk_pkg::PFN_BITS-1:0] rsp_pfn_ff;
   logic                            rsp_hit_ff;
   logic                            req_take;
   logic                            commit;
   tlbclk_pkg::bcast_type           bcast;
   tlbclk_pkg::chain_type           chain [0:tlbclk_pkg::ENTRIES];
   logic [tlbclk_pkg::ENTRIES-1:0]  touch;

   always_comb begin
      unique case (state_ff)
         tlbclk_pkg::ST_IDLE: begin
            state_in = req_valid ? tlbclk_pkg::ST_LOOKUP : tlbclk_pkg::ST_IDLE;
         end
         tlbclk_pkg::ST_LOOKUP: begin
            state_in = (!rsp_valid_ff || !rsp_stall) ? tlbclk_pkg::ST_IDLE
                                                     : tlbclk_pkg::ST_LOOKUP;
         end
         default: begin
            state_in = tlbclk_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         tlbclk_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            commit    = 1'b0;
         end
         tlbclk_pkg::ST_LOOKUP: begin
            req_stall = 1'b1;
            commit    = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
            commit    = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlbclk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         vpn_ff   <= req_vpn;
         write_ff <= req_write_access;
         fill_ff  <= req_fill_pfn;
      end
   end

   assign chain[0].hit_seen  = 1'b0;
   assign chain[0].all_valid = 1'b1;
   assign chain[0].all_used  = 1'b1;
   assign chain[0].frame     = '0;

   always_comb begin
      bcast.commit    = commit;
      bcast.miss      = !chain[tlbclk_pkg::ENTRIES].hit_seen;
      bcast.all_valid = chain[tlbclk_pkg::ENTRIES].all_valid;
      bcast.write     = write_ff;
      bcast.page      = vpn_ff;
      bcast.fill      = fill_ff;
   end

   for (genvar g = 0; g < tlbclk_pkg::ENTRIES; g++) begin : g_cell
      tlbclk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .bcast       (bcast),
         .take_wrap   ((g == 0) ? chain[tlbclk_pkg::ENTRIES].all_used : 1'b0),
         .chain_left  (chain[g]),
         .chain_right (chain[g+1]),
         .touch       (touch[g])
      );
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff <= !bcast.miss;
         rsp_pfn_ff <= bcast.miss ? fill_ff : chain[tlbclk_pkg::ENTRIES].frame;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pfn   = rsp_pfn_ff;
   assign rsp_hit   = rsp_hit_ff;

   a_one_entry_touched: assert property (@(posedge clock) disable iff (reset)
      commit |-> $onehot(touch))
      else $error("lookup commit did not touch exactly one entry");

   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("committed lookup produced no result");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == tlbclk_pkg::ST_LOOKUP))
      else $error("accepted request did not start a lookup");

endmodule

`default_nettype wire

### bench/tlb_lookup_clock_replace_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tlb_lookup_clock_replace_top: random request and response
// idling, with an in-bench TLB predictor that tracks valid, used and dirty bits per entry.
// Depends on tlbclk_pkg and the RTL of tlb_lookup_clock_replace_top.

module tlb_lookup_clock_replace_top_tb;
   import tlbclk_pkg::*;

   typedef struct packed {
      logic [VPN_BITS-1:0] vpn;
      logic                write;
      logic [PFN_BITS-1:0] fill;
   } access_type;

   typedef struct packed {
      logic [PFN_BITS-1:0] pfn;
      logic                hit;
   } xlat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [VPN_BITS-1:0] req_vpn = '0;
   logic                req_write_access = 1'b0;
   logic [PFN_BITS-1:0] req_fill_pfn = '0;
   logic                rsp_stall = 1'b0;
   wire                 req_stall;
   wire                 rsp_valid;
   wire [PFN_BITS-1:0]  rsp_pfn;
   wire                 rsp_hit;

   access_type          access_q[$];
   xlat_type            xlat_q[$];
   access_type          next_access;
   xlat_type            seen_xlat;

   logic                tlb_valid[ENTRIES];
   logic                tlb_used[ENTRIES];
   logic                tlb_dirty[ENTRIES];
   logic [VPN_BITS-1:0] tlb_page[ENTRIES];
   logic [PFN_BITS-1:0] tlb_frame[ENTRIES];
   logic [VPN_BITS-1:0] hot_pages[20];

   int                  errors = 0;
   int                  accepted = 0;
   bit                  taken_now = 1'b0;
   wire                 calm = accepted >= 500 && accepted < 800;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   tlb_lookup_clock_replace_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vpn          (req_vpn),
      .req_write_access (req_write_access),
      .req_fill_pfn     (req_fill_pfn),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pfn          (rsp_pfn),
      .rsp_hit          (rsp_hit)
   );

   // On a miss the lowest invalid entry is filled; with every entry valid, a clock
   // sweep from entry 0 clears used bits and wraps back to entry 0 if all were used.
   task automatic predict_translation(input access_type a);
      int       slot;
      bit       found;
      bit       chosen;
      xlat_type x;
      slot   = 0;
      found  = 1'b0;
      chosen = 1'b0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (!found && tlb_valid[k] && tlb_page[k] == a.vpn) begin
            slot  = k;
            found = 1'b1;
         end
      end
      if (found) begin
         x.pfn = tlb_frame[slot];
      end else begin
         x.pfn = a.fill;
         for (int k = 0; k < ENTRIES; k++) begin
            if (!chosen && !tlb_valid[k]) begin
               slot   = k;
               chosen = 1'b1;
            end
         end
         for (int k = 0; k < ENTRIES; k++) begin
            if (!chosen) begin
               if (!tlb_used[k]) begin
                  slot   = k;
                  chosen = 1'b1;
               end else begin
                  tlb_used[k] = 1'b0;
               end
            end
         end
         if (!chosen) begin
            slot = 0;
         end
         tlb_page[slot]  = a.vpn;
         tlb_frame[slot] = a.fill;
         tlb_valid[slot] = 1'b1;
         tlb_dirty[slot] = 1'b0;
      end
      if (a.write) begin
         tlb_dirty[slot] = 1'b1;
      end
      tlb_used[slot] = 1'b1;
      x.hit = found;
      xlat_q.push_back(x);
   endtask

   task automatic queue_access(input logic [VPN_BITS-1:0] vpn, input logic write,
                               input logic [PFN_BITS-1:0] fill);
      access_type a;
      a.vpn   = vpn;
      a.write = write;
      a.fill  = fill;
      access_q.push_back(a);
   endtask

   task automatic wait_drained();
      while (access_q.size() != 0 || req_valid || xlat_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 38);
         if (!req_valid || taken_now) begin
            if (access_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
               next_access = access_q.pop_front();
               req_valid        <= 1'b1;
               req_vpn          <= next_access.vpn;
               req_write_access <= next_access.write;
               req_fill_pfn     <= next_access.fill;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      taken_now = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken_now = 1'b1;
            accepted++;
            next_access.vpn   = req_vpn;
            next_access.write = req_write_access;
            next_access.fill  = req_fill_pfn;
            predict_translation(next_access);
         end
         if (rsp_valid && !rsp_stall) begin
            if (xlat_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response pfn=%h hit=%b", $time, rsp_pfn, rsp_hit);
            end else begin
               seen_xlat = xlat_q.pop_front();
               if (rsp_pfn !== seen_xlat.pfn) begin
                  errors++;
                  $display("%0t: pfn expected %h actual %h", $time, seen_xlat.pfn, rsp_pfn);
               end
               if (rsp_hit !== seen_xlat.hit) begin
                  errors++;
                  $display("%0t: hit expected %b actual %b", $time, seen_xlat.hit, rsp_hit);
               end
            end
         end
      end
   end

   initial begin
      int pick;
      logic [VPN_BITS-1:0] vpn;
      for (int k = 0; k < ENTRIES; k++) begin
         tlb_valid[k] = 1'b0;
         tlb_used[k]  = 1'b0;
         tlb_dirty[k] = 1'b0;
         tlb_page[k]  = '0;
         tlb_frame[k] = '0;
      end
      for (int i = 0; i < 20; i++) begin
         hot_pages[i] = VPN_BITS'($urandom());
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes of page and frame, hits on read and write, then a full table
      // with every used bit set so that the sweep wraps to entry 0.
      queue_access('0, 1'b0, '1);
      queue_access('0, 1'b1, '0);
      queue_access('1, 1'b1, '0);
      queue_access('1, 1'b0, PFN_BITS'(20'h12345));
      for (int i = 2; i < ENTRIES; i++) begin
         queue_access(VPN_BITS'(32'h100 + i), i[0], PFN_BITS'(32'h800 + i));
      end
      queue_access(VPN_BITS'(32'h200), 1'b0, PFN_BITS'(32'h55555));
      queue_access('0, 1'b0, PFN_BITS'(32'haaaaa));
      queue_access('1, 1'b1, PFN_BITS'(32'h0f0f0));
      queue_access(VPN_BITS'(32'h200), 1'b1, PFN_BITS'(32'h33333));
      queue_access(VPN_BITS'(32'h103), 1'b1, '1);
      wait_drained();

      for (int i = 0; i < 1450; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            vpn = hot_pages[$urandom_range(0, 19)];
         end else if (pick < 85) begin
            vpn = VPN_BITS'($urandom_range(0, 3));
         end else begin
            vpn = VPN_BITS'($urandom());
         end
         queue_access(vpn, 1'($urandom_range(0, 1)), PFN_BITS'($urandom()));
         if (i == 700) begin
            wait_drained();
         end
      end
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
src/tlbclk_pkg.sv
src/tlbclk_cell.sv
src/tlb_lookup_clock_replace_top.sv
bench/tlb_lookup_clock_replace_top_tb.sv
